// ===== design/rti_pkg.sv =====
// ----------------------------------------------------------------------------
// rti_pkg
// Shared constants and types for the ray / triangle intersection pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package rti_pkg;

  // default coordinate format, signed Q16.16
  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;

  // configuration register index codes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_X    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_Y    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_Z    = 3'd5;

  // control flags that travel with each request through the divider
  typedef struct packed {
    logic valid;
    logic hit;
    logic neg;
    logic ovf;
  } rti_ctl_t;

endpackage

`default_nettype wire

// ===== design/rti_if.sv =====
// ----------------------------------------------------------------------------
// rti_if
// Valid/ready channel interfaces: triangle input, result output, config write.
// ----------------------------------------------------------------------------
`default_nettype none

interface rti_tri_if #(parameter int W = rti_pkg::COORD_WIDTH_DEF);
  logic valid;
  logic ready;
  logic signed [W-1:0] vert0_x, vert0_y, vert0_z;
  logic signed [W-1:0] vert1_x, vert1_y, vert1_z;
  logic signed [W-1:0] vert2_x, vert2_y, vert2_z;
  modport source(output valid, vert0_x, vert0_y, vert0_z, vert1_x, vert1_y, vert1_z,
                 vert2_x, vert2_y, vert2_z, input ready);
  modport sink(input valid, vert0_x, vert0_y, vert0_z, vert1_x, vert1_y, vert1_z,
               vert2_x, vert2_y, vert2_z, output ready);
endinterface

interface rti_res_if #(parameter int W = rti_pkg::COORD_WIDTH_DEF);
  logic valid;
  logic ready;
  logic hit;
  logic signed [W-1:0] hit_distance;
  modport source(output valid, hit, hit_distance, input ready);
  modport sink(input valid, hit, hit_distance, output ready);
endinterface

interface rti_cfg_if #(parameter int W = rti_pkg::COORD_WIDTH_DEF);
  logic valid;
  logic ready;
  logic [rti_pkg::CFG_IDX_W-1:0] index;
  logic [W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== design/ray_triangle_intersect.sv =====
// A triangle request passes the geometry front end, the divider back end and the output register.
// Throughput: one triangle per cycle while no result is held; the divider yields one quotient bit per stage.
// The whole pipeline holds while a result waits at the output register.
// Reset (synchronous, rst high) clears all valid bits and sets the ray to
// origin 0 and direction (0, 0, 1.0).
// ----------------------------------------------------------------------------
// ray_triangle_intersect
// Moller-Trumbore ray / triangle test over a stream of triangles against a
// ray held in configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none

module ray_triangle_intersect #(
  parameter int COORD_WIDTH = rti_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = rti_pkg::FRAC_BITS_DEF
) (
  input logic        clk,
  input logic        rst,
  rti_cfg_if.sink    cfg,
  rti_tri_if.sink    tri_in,
  rti_res_if.source  res_out
);

  localparam int W  = COORD_WIDTH;
  localparam int DW = W + 1;
  localparam int XW = 2 * DW + 1;
  localparam int PW = DW + XW + 2;

  logic signed [W-1:0] org [3], dir [3], v0 [3], v1 [3], v2 [3];
  logic                en;
  logic                g_valid;
  logic signed [PW-1:0] det, tn, un, vn;

  // ray registers, written from the config channel
  always_ff @(posedge clk) begin
    if (rst) begin
      org[0] <= '0; org[1] <= '0; org[2] <= '0;
      dir[0] <= '0; dir[1] <= '0;
      dir[2] <= W'(1) << FRAC_BITS;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        rti_pkg::REG_ORIGIN_X: org[0] <= cfg.data;
        rti_pkg::REG_ORIGIN_Y: org[1] <= cfg.data;
        rti_pkg::REG_ORIGIN_Z: org[2] <= cfg.data;
        rti_pkg::REG_DIR_X:    dir[0] <= cfg.data;
        rti_pkg::REG_DIR_Y:    dir[1] <= cfg.data;
        rti_pkg::REG_DIR_Z:    dir[2] <= cfg.data;
        default: ;
      endcase
    end
  end

  assign cfg.ready = 1'b1;

  // advance the pipeline unless a result is held
  assign en = !res_out.valid || res_out.ready;
  assign tri_in.ready = en;

  assign v0[0] = tri_in.vert0_x; assign v0[1] = tri_in.vert0_y; assign v0[2] = tri_in.vert0_z;
  assign v1[0] = tri_in.vert1_x; assign v1[1] = tri_in.vert1_y; assign v1[2] = tri_in.vert1_z;
  assign v2[0] = tri_in.vert2_x; assign v2[1] = tri_in.vert2_y; assign v2[2] = tri_in.vert2_z;

  rti_geom #(.W(W), .DW(DW), .XW(XW), .PW(PW)) u_geom (
    .clk, .rst, .en,
    .in_valid (tri_in.valid),
    .org, .dir, .v0, .v1, .v2,
    .out_valid(g_valid),
    .det, .tn, .un, .vn
  );

  rti_div #(.W(W), .F(FRAC_BITS), .PW(PW)) u_div (
    .clk, .rst, .en,
    .in_valid (g_valid),
    .det, .tn, .un, .vn,
    .out_valid(res_out.valid),
    .out_hit  (res_out.hit),
    .out_dist (res_out.hit_distance)
  );

`ifndef SYNTH
  // a miss reports zero distance
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    res_out.valid && !res_out.hit |-> res_out.hit_distance == '0)
    else $error("miss with nonzero distance");

  // a held result blocks new requests
  a_hold_blocks: assert property (@(posedge clk) disable iff (rst)
    res_out.valid && !res_out.ready |-> !tri_in.ready)
    else $error("request taken while result held");

  // reset restores the default direction
  a_reset_dir: assert property (@(posedge clk)
    rst |=> dir[2] == (W'(1) << FRAC_BITS))
    else $error("direction z not reset to one");
`endif

endmodule

`default_nettype wire

// ===== design/rti_geom.sv =====
// ----------------------------------------------------------------------------
// rti_geom
// Six-stage front end: edges, cross products and the four dot products
// (determinant and the t, u, v numerators) at full precision.
// ----------------------------------------------------------------------------
`default_nettype none

module rti_geom #(
  parameter int W  = rti_pkg::COORD_WIDTH_DEF,
  parameter int DW = W + 1,
  parameter int XW = 2 * DW + 1,
  parameter int PW = DW + XW + 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [W-1:0]  org [3],
  input  logic signed [W-1:0]  dir [3],
  input  logic signed [W-1:0]  v0  [3],
  input  logic signed [W-1:0]  v1  [3],
  input  logic signed [W-1:0]  v2  [3],
  output logic                 out_valid,
  output logic signed [PW-1:0] det,
  output logic signed [PW-1:0] tn,
  output logic signed [PW-1:0] un,
  output logic signed [PW-1:0] vn
);

  localparam int LW = XW / 2;
  localparam int HW = XW - LW;
  localparam int TW = DW + XW;

  logic [6:1] vld;

  logic signed [DW-1:0] e1_1 [3], e2_1 [3], m_1 [3], d_1 [3];
  logic signed [DW-1:0] e1_2 [3], e2_2 [3], m_2 [3], d_2 [3];
  logic signed [DW-1:0] e1_3 [3], e2_3 [3], m_3 [3], d_3 [3];
  logic signed [2*DW-1:0] p1a [3], p1b [3], p2a [3], p2b [3];
  logic signed [XW-1:0] x1 [3], x2 [3];
  logic signed [DW-1:0] lhs [4][3];
  logic signed [XW-1:0] rhs [4][3];
  logic signed [DW+HW-1:0] ph [4][3];
  logic signed [DW+LW:0] pl [4][3];
  logic signed [TW-1:0] term [4][3];
  logic signed [PW-1:0] sum [4];

  // advance valid bits with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[5:1], in_valid};
    end
  end

  // operand pairing of the four dot products
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      lhs[0][k] = e1_3[k]; rhs[0][k] = x2[k];
      lhs[1][k] = e2_3[k]; rhs[1][k] = x1[k];
      lhs[2][k] = m_3[k];  rhs[2][k] = x2[k];
      lhs[3][k] = d_3[k];  rhs[3][k] = x1[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        // stage 1: edges and origin offset
        e1_1[k] <= DW'(v1[k]) - DW'(v0[k]);
        e2_1[k] <= DW'(v2[k]) - DW'(v0[k]);
        m_1[k]  <= DW'(org[k]) - DW'(v0[k]);
        d_1[k]  <= DW'(dir[k]);
        // stage 2: cross product terms
        p1a[k] <= m_1[(k+1)%3] * e1_1[(k+2)%3];
        p1b[k] <= m_1[(k+2)%3] * e1_1[(k+1)%3];
        p2a[k] <= d_1[(k+1)%3] * e2_1[(k+2)%3];
        p2b[k] <= d_1[(k+2)%3] * e2_1[(k+1)%3];
        e1_2[k] <= e1_1[k]; e2_2[k] <= e2_1[k]; m_2[k] <= m_1[k]; d_2[k] <= d_1[k];
        // stage 3: cross products
        x1[k] <= XW'(p1a[k]) - XW'(p1b[k]);
        x2[k] <= XW'(p2a[k]) - XW'(p2b[k]);
        e1_3[k] <= e1_2[k]; e2_3[k] <= e2_2[k]; m_3[k] <= m_2[k]; d_3[k] <= d_2[k];
      end
      for (int j = 0; j < 4; j++) begin
        for (int k = 0; k < 3; k++) begin
          // stage 4: split products, high half signed, low half unsigned
          ph[j][k] <= lhs[j][k] * $signed(rhs[j][k][XW-1:LW]);
          pl[j][k] <= lhs[j][k] * $signed({1'b0, rhs[j][k][LW-1:0]});
          // stage 5: recombine halves
          term[j][k] <= (TW'(ph[j][k]) <<< LW) + TW'(pl[j][k]);
        end
        // stage 6: sum of the three terms
        sum[j] <= PW'(term[j][0]) + PW'(term[j][1]) + PW'(term[j][2]);
      end
    end
  end

  assign out_valid = vld[6];
  assign det = sum[0];
  assign tn  = sum[1];
  assign un  = sum[2];
  assign vn  = sum[3];

endmodule

`default_nettype wire

// ===== design/rti_div.sv =====
// ----------------------------------------------------------------------------
// rti_div
// Back end: sign normalize, barycentric test, then a restoring divider of
// one quotient bit per stage and saturation of the distance.
// ----------------------------------------------------------------------------
`default_nettype none

module rti_div #(
  parameter int W  = rti_pkg::COORD_WIDTH_DEF,
  parameter int F  = rti_pkg::FRAC_BITS_DEF,
  parameter int PW = 3 * W + 6
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [PW-1:0] det,
  input  logic signed [PW-1:0] tn,
  input  logic signed [PW-1:0] un,
  input  logic signed [PW-1:0] vn,
  output logic                 out_valid,
  output logic                 out_hit,
  output logic signed [W-1:0]  out_dist
);

  localparam int CW = PW + ((F > W) ? F : W);

  // stage A: sign normalized terms
  logic                 va, nza;
  logic signed [PW-1:0] det_a, tn_a, un_a, vn_a;
  // stage B: hit decision and magnitude
  logic                 vb, hit_b, neg_b;
  logic [PW-1:0]        det_b, mag_b;
  logic signed [PW+1:0] slack;

  logic [CW-1:0]        rem [0:W];
  logic [W-1:0]         quo [0:W];
  logic [PW-1:0]        den [0:W];
  rti_pkg::rti_ctl_t    ctl [0:W];

  logic [W-1:0]         lim, qs;

  assign slack = (PW+2)'(det_a) - (PW+2)'(un_a) - (PW+2)'(vn_a);

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      ctl[0].valid <= 1'b0;
    end else if (en) begin
      va <= in_valid;
      vb <= va;
      ctl[0].valid <= vb;
    end
    if (en) begin
      // flip signs so the determinant is not negative
      nza <= (det != '0);
      det_a <= det[PW-1] ? -det : det;
      tn_a  <= det[PW-1] ? -tn  : tn;
      un_a  <= det[PW-1] ? -un  : un;
      vn_a  <= det[PW-1] ? -vn  : vn;
      // decide u >= 0, v >= 0, u + v <= 1 on the numerators
      hit_b <= nza && !un_a[PW-1] && !vn_a[PW-1] && !slack[PW+1];
      neg_b <= tn_a[PW-1];
      mag_b <= tn_a[PW-1] ? PW'(-tn_a) : PW'(tn_a);
      det_b <= PW'(det_a);
      // scale numerator, flag a quotient of 2^W or more
      rem[0] <= CW'(mag_b) << F;
      quo[0] <= '0;
      den[0] <= det_b;
      ctl[0].hit <= hit_b;
      ctl[0].neg <= neg_b;
      ctl[0].ovf <= (CW'(mag_b) << F) >= (CW'(det_b) << W);
    end
  end

  // one quotient bit per stage, most significant first
  for (genvar j = 0; j < W; j++) begin : g_bit
    localparam int SH = W - 1 - j;
    logic [CW-1:0] sd;
    logic          take;
    assign sd   = CW'(den[j]) << SH;
    assign take = (rem[j] >= sd);
    always_ff @(posedge clk) begin
      if (rst) begin
        ctl[j+1].valid <= 1'b0;
      end else if (en) begin
        ctl[j+1].valid <= ctl[j].valid;
      end
      if (en) begin
        rem[j+1] <= take ? rem[j] - sd : rem[j];
        quo[j+1] <= take ? (quo[j] | (W'(1) << SH)) : quo[j];
        den[j+1] <= den[j];
        ctl[j+1].hit <= ctl[j].hit;
        ctl[j+1].neg <= ctl[j].neg;
        ctl[j+1].ovf <= ctl[j].ovf;
      end
    end
  end

  // saturate to the signed range and apply the sign
  assign lim = ctl[W].neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
  assign qs  = (ctl[W].ovf || quo[W] > lim) ? lim : quo[W];

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= ctl[W].valid;
    end
    if (en) begin
      out_hit  <= ctl[W].hit;
      out_dist <= !ctl[W].hit ? '0 : (ctl[W].neg ? $signed(-qs) : $signed(qs));
    end
  end

endmodule

`default_nettype wire
